@@ rtl/core/range_max_min_sparse_table_unit_assert.svh @@
// assertion macros for the range max/min sparse table unit
// used by the port checker; no other dependencies
`ifndef RANGE_MAX_MIN_SPARSE_TABLE_UNIT_ASSERT_SVH
`define RANGE_MAX_MIN_SPARSE_TABLE_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RMM_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define RMM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

@@ rtl/core/rmm_pkg.sv @@
// shared types and constants for the range max/min sparse table unit
// no dependencies
package rmm_pkg;
    localparam int unsigned MAX_ELEMENTS_DEF = 1024;
    localparam int unsigned VALUE_WIDTH_DEF  = 32;
    localparam int unsigned IDX_W            = 10;
    localparam int unsigned FIELD_W          = 32;

    // request kinds carried on tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_RD0,
        ST_BUILD_RD1,
        ST_BUILD_WR,
        ST_QUERY_RD,
        ST_QUERY_RES,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;       // store pair at count
        logic restart;    // restart count with this pair, clear built flag
        logic build_init; // start build at level 1
        logic build_rd0;
        logic build_rd1;
        logic build_wr;   // write and advance
        logic build_done;
        logic query_rd;
        logic query_res;
        logic out_take;
    } t_cmd;

    typedef struct packed {
        logic built;
        logic build_level_ok; // another level to do
        logic build_last;     // last entry of this level
        logic full;
    } t_status;
endpackage

@@ rtl/core/rmm_datapath.sv @@
// datapath of the range max/min unit: table memories, counters, query logic
// depends on rmm_pkg
module rmm_datapath #(
    parameter int unsigned MAX_ELEMENTS = 1024,
    parameter int unsigned VALUE_WIDTH  = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rmm_pkg::t_cmd           i_cmd,
    output rmm_pkg::t_status        o_status,
    input  logic [rmm_pkg::FIELD_W-1:0] i_value_a,
    input  logic [rmm_pkg::FIELD_W-1:0] i_value_b,
    input  logic [rmm_pkg::IDX_W-1:0]   i_left,
    input  logic [rmm_pkg::IDX_W-1:0]   i_right,
    output logic [rmm_pkg::FIELD_W-1:0] o_range_max,
    output logic [rmm_pkg::FIELD_W-1:0] o_range_min,
    output logic                    o_error
);
    import rmm_pkg::*;

    localparam int unsigned AW     = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW     = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned LEVELS = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned LW     = $clog2(LEVELS + 1);
    localparam int unsigned DEPTH  = MAX_ELEMENTS * LEVELS;
    localparam int unsigned MW     = $clog2(DEPTH);
    localparam int unsigned QW     = (IDX_W > CW) ? IDX_W + 1 : CW + 1;

    logic [VALUE_WIDTH-1:0] mem_a [DEPTH];
    logic [VALUE_WIDTH-1:0] mem_b [DEPTH];

    logic [CW-1:0] r_count;
    logic          r_built;
    logic [LW-1:0] r_lvl;
    logic [CW-1:0] r_i;
    logic [VALUE_WIDTH-1:0] r_a0, r_b0, r_rd_a, r_rd_b;
    logic [QW-1:0] r_ql, r_qh;
    logic [LW-1:0] r_qk;
    logic          r_qerr;
    logic [FIELD_W-1:0] r_max, r_min;
    logic          r_err;

    // memory address mux
    logic [MW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic          rd_en;
    logic [VALUE_WIDTH-1:0] wd_a, wd_b;
    logic [CW:0]   half, span;
    logic [QW-1:0] len, ql;
    logic [LW-1:0] lvl_m1, qk;
    logic          qerr;

    function automatic logic [MW-1:0] slot(input logic [LW-1:0] lv, input logic [QW-1:0] ix);
        logic [MW+LW:0] s;
        s = (MW+LW+1)'(lv) * (MW+LW+1)'(MAX_ELEMENTS) + (MW+LW+1)'(ix);
        return s[MW-1:0];
    endfunction

    always_comb begin
        lvl_m1 = r_lvl - LW'(1);
        half   = (CW+1)'(1) << lvl_m1;
        span   = (CW+1)'(1) << r_lvl;
        len    = QW'(i_right) - QW'(i_left) + QW'(1);
        qk     = '0;
        for (int k = 1; k < LEVELS; k++) begin
            if (len[QW-1:0] >= (QW'(1) << k)) qk = LW'(k);
        end
        qerr = !r_built || (i_left > i_right) || (QW'(i_right) >= QW'(r_count));
        ql   = QW'(i_left);
        rd_addr = '0;
        if (i_cmd.build_rd0)      rd_addr = slot(lvl_m1, QW'(r_i));
        else if (i_cmd.build_rd1) rd_addr = slot(lvl_m1, QW'(r_i) + QW'(half));
        else if (i_cmd.query_rd)  rd_addr = slot(qk, ql);
        else if (i_cmd.query_res) rd_addr = slot(r_qk, r_qh);
        // read data holds between reads so a stalled result keeps its operands
        rd_en   = i_cmd.build_rd0 || i_cmd.build_rd1 || i_cmd.query_rd || i_cmd.query_res;
        wr_en   = i_cmd.load || i_cmd.build_wr;
        wr_addr = i_cmd.load ? slot('0, QW'(i_cmd.restart ? '0 : r_count))
                             : slot(r_lvl, QW'(r_i));
        wd_a = i_cmd.load ? VALUE_WIDTH'(i_value_a)
             : (($signed(r_rd_a) > $signed(r_a0)) ? r_rd_a : r_a0);
        wd_b = i_cmd.load ? VALUE_WIDTH'(i_value_b)
             : (($signed(r_b0) > $signed(r_rd_b)) ? r_rd_b : r_b0);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !(i_cmd.load && o_status.full && !i_cmd.restart)) begin
            mem_a[wr_addr] <= wd_a;
            mem_b[wr_addr] <= wd_b;
        end
        if (rd_en) begin
            r_rd_a <= mem_a[rd_addr];
            r_rd_b <= mem_b[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_built <= 1'b0;
            r_lvl   <= '0;
            r_i     <= '0;
        end else begin
            if (i_cmd.load) begin
                if (i_cmd.restart) begin
                    r_count <= CW'(1);
                    r_built <= 1'b0;
                end else if (!o_status.full) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.build_init) begin
                r_lvl <= LW'(1);
                r_i   <= '0;
            end
            if (i_cmd.build_wr) begin
                if (o_status.build_last) begin
                    r_lvl <= r_lvl + LW'(1);
                    r_i   <= '0;
                end else begin
                    r_i <= r_i + CW'(1);
                end
            end
            if (i_cmd.build_done) r_built <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_rd1) begin
            r_a0 <= r_rd_a;
            r_b0 <= r_rd_b;
        end
        if (i_cmd.query_rd) begin
            r_qk   <= qk;
            r_qh   <= QW'(i_right) + QW'(1) - (QW'(1) << qk);
            r_qerr <= qerr;
        end
        if (i_cmd.query_res) begin
            r_a0 <= r_rd_a;
            r_b0 <= r_rd_b;
        end
        if (i_cmd.out_take) begin
            r_err <= r_qerr;
            r_max <= r_qerr ? '0 : FIELD_W'(($signed(r_rd_a) > $signed(r_a0)) ? r_rd_a : r_a0);
            r_min <= r_qerr ? '0 : FIELD_W'(($signed(r_b0) > $signed(r_rd_b)) ? r_rd_b : r_b0);
        end
    end

    assign o_status.built          = r_built;
    assign o_status.full           = (r_count == CW'(MAX_ELEMENTS));
    assign o_status.build_level_ok = (r_lvl < LW'(LEVELS)) && ((CW+1)'(r_count) >= span);
    assign o_status.build_last     = ((CW+1)'(r_i) + span + (CW+1)'(1)) > (CW+1)'(r_count);
    assign o_range_max = r_max;
    assign o_range_min = r_min;
    assign o_error     = r_err;
endmodule

@@ rtl/core/rmm_ctrl.sv @@
// controller state machine for the range max/min unit
// depends on rmm_pkg
module rmm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic             i_req_query,
    input  logic             i_req_last,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    input  rmm_pkg::t_status i_status,
    output rmm_pkg::t_cmd    o_cmd
);
    import rmm_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        if (r_valid && i_res_ready) n_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_query) begin
                        o_cmd.query_rd = 1'b1;
                        n_state = ST_QUERY_RD;
                    end else begin
                        o_cmd.load    = 1'b1;
                        o_cmd.restart = i_status.built;
                        if (i_req_last) begin
                            o_cmd.build_init = 1'b1;
                            n_state = ST_BUILD_RD0;
                        end
                    end
                end
            end
            ST_BUILD_RD0: begin
                if (i_status.build_level_ok) begin
                    o_cmd.build_rd0 = 1'b1;
                    n_state = ST_BUILD_RD1;
                end else begin
                    o_cmd.build_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_BUILD_RD1: begin
                o_cmd.build_rd1 = 1'b1;
                n_state = ST_BUILD_WR;
            end
            ST_BUILD_WR: begin
                o_cmd.build_wr = 1'b1;
                n_state = ST_BUILD_RD0;
            end
            ST_QUERY_RD: begin
                o_cmd.query_res = 1'b1;
                n_state = ST_QUERY_RES;
            end
            ST_QUERY_RES: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_valid || i_res_ready) begin
                    o_cmd.out_take = 1'b1;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_res_valid = r_valid;
endmodule

@@ rtl/core/range_max_min_sparse_table_unit.sv @@
// top level of the range max/min sparse table unit
// depends on rmm_pkg, rmm_ctrl, rmm_datapath
//
// channel | dir | tdata (low bit up)                          | tuser | tlast
// s_axis  | in  | value_a[31:0] value_b[63:32] left[73:64]     | cmd   | last_element
//         |     | right[83:74], zero fill to 88                |       |
// m_axis  | out | range_max[31:0] range_min[63:32]             | error | -
//
// a query makes two table reads, then the compare loads its result register, and the
// input is ready again once back in ST_IDLE; it is not ready during a build
// the last load starts a build that runs each table entry through ST_BUILD_RD0,
// ST_BUILD_RD1 and ST_BUILD_WR over all levels, then sets the built flag
// synchronous active-low reset clears the count and built flag; tables are not cleared
// a held result does not block loads; a later query waits in its last cycle until the
// output register is taken or empty
module range_max_min_sparse_table_unit #(
    parameter int unsigned MAX_ELEMENTS = rmm_pkg::MAX_ELEMENTS_DEF,
    parameter int unsigned VALUE_WIDTH  = rmm_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // value_a, value_b, left_index, right_index
    input  logic        s_axis_tuser,  // cmd
    input  logic        s_axis_tlast,  // last_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // range_max, range_min
    output logic        m_axis_tuser   // error
);
    import rmm_pkg::*;

    t_cmd    cmd;
    t_status status;

    rmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req_query (s_axis_tuser),
        .i_req_last  (s_axis_tlast),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rmm_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value_a   (s_axis_tdata[31:0]),
        .i_value_b   (s_axis_tdata[63:32]),
        .i_left      (s_axis_tdata[73:64]),
        .i_right     (s_axis_tdata[83:74]),
        .o_range_max (m_axis_tdata[31:0]),
        .o_range_min (m_axis_tdata[63:32]),
        .o_error     (m_axis_tuser)
    );
endmodule

@@ rtl/core/rmm_checker.sv @@
// port checker for the range max/min unit, bound to the top level
// depends on range_max_min_sparse_table_unit_assert.svh
`include "range_max_min_sparse_table_unit_assert.svh"
module rmm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    `RMM_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `RMM_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0, "error result carries data")
    `RMM_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "query not held off next cycle")
endmodule

bind range_max_min_sparse_table_unit rmm_checker u_rmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
